// File: hdl/ftws_pkg.sv
// Shared types and constants for the frame time window statistics block.
// No dependencies; imported by the top level of the block.
package ftws_pkg;

    localparam int unsigned DEFAULT_DEPTH = 240;
    localparam int unsigned SAMPLE_W      = 20;
    localparam int unsigned FRAC_W        = 14;
    localparam int unsigned RATE_W        = 28;
    localparam int unsigned COUNT_OUT_W   = 8;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned RATE_ONE_Q8   = 256000000;
    localparam int unsigned PCT_SCALE     = 10000;
    localparam int unsigned LOW_A_RESET   = 100;
    localparam int unsigned LOW_B_RESET   = 10;

    // floor(p / 10000) = (p * PCT_RECIP) >> PCT_SHIFT, exact for p below 2^27
    localparam int unsigned PCT_RECIP_W   = 28;
    localparam int unsigned PCT_RECIP     = 219902326;
    localparam int unsigned PCT_SHIFT     = 41;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_B = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_KSCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD,
        ST_EMIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_RA,
        OP_RB,
        OP_INST
    } op_t;

endpackage

// File: hdl/ftws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ftws_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 240
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/ftws_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing; used by the top level for the rate quotients.
module ftws_div #(
    parameter int unsigned DVD_W = 36,
    parameter int unsigned DVS_W = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int unsigned CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/frame_time_window_statistics.sv
// Top level of the frame time window statistics block.
// Depends on ftws_pkg, ftws_ram and ftws_div.
//
// Each request carries one frame time in microseconds and yields one result:
// the instantaneous rate, two percentile-low rates (rate of the mean of the
// slowest k samples, k = floor(count*fraction/10000) held in 1..count), the
// upper median, the worst sample and the fill count. Rates are Q8 frames per
// second, saturated at 256000000 and 0 when the divisor sum is 0. Samples sit
// in a ring RAM; a sorted copy of the window lives in two ping-pong RAMs.
// Per request the sorted list is rebuilt in one merge pass that drops the
// evicted sample and inserts the new one, and the order statistics and
// top-k sums are taken on the fly. Both k values come from a reciprocal
// multiplication. Three rate quotients then go through one shared
// bit-serial divider, which is skipped when the divisor is 0. One request is
// processed at a time; a finished result waits in the output register while
// the next request is taken. No clearing pass is needed after reset.
module frame_time_window_statistics
    import ftws_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = ftws_pkg::DEFAULT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [ftws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftws_pkg::FRAC_W-1:0]    cfg_wdata,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // frame_time_us[19:0], zero pad
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // inst_fps_q8[27:0], low_a_fps_q8[55:28], low_b_fps_q8[83:56],
    // median_us[103:84], worst_us[123:104], filled_count[131:124], zero pad
    output logic [135:0]                   m_axis_tdata
);

    localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W = SAMPLE_W + CNT_W;
    localparam int unsigned DVD_W = RATE_W + CNT_W + 1;
    localparam int unsigned DVS_W = SUM_W;
    localparam int unsigned PROD_W = CNT_W + FRAC_W;
    localparam int unsigned MUL_W  = PROD_W + PCT_RECIP_W;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [FRAC_W-1:0]   fa_reg, fb_reg;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] e_reg, e_next;
    logic [CNT_W-1:0]    m_reg, m_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                full_reg, full_next;
    logic [CNT_W-1:0]    ka_reg, ka_next, kb_reg, kb_next;
    logic [PROD_W-1:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic [RATE_W-1:0]   ra_reg, ra_next, rb_reg, rb_next, inst_reg, inst_next;
    logic [CNT_W-1:0]    r_reg, r_next, w_reg, w_next;
    logic                ins_reg, ins_next, skip_reg, skip_next;
    logic [SUM_W-1:0]    sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [SAMPLE_W-1:0] med_reg, med_next, worst_reg, worst_next;
    logic                sel_reg, sel_next;
    logic                out_valid_reg, out_valid_next;
    logic [135:0]        out_data_reg, out_data_next;

    // memory ports
    logic                ring_re, ring_we;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                srt_re, emit;
    logic [SAMPLE_W-1:0] emit_val;
    logic [SAMPLE_W-1:0] srt0_rdata, srt1_rdata, old_d;

    // divider
    logic             div_start, div_done;
    logic [DVD_W-1:0] dvd, div_q, res_q;
    logic [DVS_W-1:0] dvs;
    logic             res_valid;
    logic             have;
    logic             accept;
    logic [RATE_W-1:0] rate_sat;

    // percentile counts
    logic [MUL_W-1:0] qa_full, qb_full;
    logic [CNT_W:0]   qa, qb;
    logic [CNT_W-1:0] ka_clamped, kb_clamped;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg <= FRAC_W'(LOW_A_RESET);
            fb_reg <= FRAC_W'(LOW_B_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_A: fa_reg <= cfg_wdata;
                CFG_LOW_B: fb_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    ftws_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (ring_re),
        .raddr (wp_reg),
        .rdata (ring_rdata)
    );

    // sorted ping-pong buffers: sel_reg names the one holding the old list
    ftws_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_sorted0 (
        .clk   (clk),
        .we    (emit && sel_reg),
        .waddr (w_reg[IDX_W-1:0]),
        .wdata (emit_val),
        .re    (srt_re && !sel_reg),
        .raddr (r_reg[IDX_W-1:0]),
        .rdata (srt0_rdata)
    );

    ftws_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_sorted1 (
        .clk   (clk),
        .we    (emit && !sel_reg),
        .waddr (w_reg[IDX_W-1:0]),
        .wdata (emit_val),
        .re    (srt_re && sel_reg),
        .raddr (r_reg[IDX_W-1:0]),
        .rdata (srt1_rdata)
    );

    assign old_d = sel_reg ? srt1_rdata : srt0_rdata;

    ftws_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // k = floor(count * fraction / 10000) by reciprocal, then held in 1..count
    assign qa_full = MUL_W'(pa_reg) * MUL_W'(PCT_RECIP);
    assign qb_full = MUL_W'(pb_reg) * MUL_W'(PCT_RECIP);
    assign qa = qa_full[PCT_SHIFT +: (CNT_W + 1)];
    assign qb = qb_full[PCT_SHIFT +: (CNT_W + 1)];
    assign ka_clamped = (qa == '0) ? CNT_W'(1)
                      : (qa > {1'b0, n_reg}) ? n_reg : qa[CNT_W-1:0];
    assign kb_clamped = (qb == '0) ? CNT_W'(1)
                      : (qb > {1'b0, n_reg}) ? n_reg : qb[CNT_W-1:0];

    // operand select for the shared divider
    always_comb
    begin
        case (op_reg)
            OP_RA:
            begin
                dvd = DVD_W'(RATE_ONE_Q8) * DVD_W'(ka_reg);
                dvs = sum_a_reg;
            end
            OP_RB:
            begin
                dvd = DVD_W'(RATE_ONE_Q8) * DVD_W'(kb_reg);
                dvs = sum_b_reg;
            end
            default:
            begin
                dvd = DVD_W'(RATE_ONE_Q8);
                dvs = DVS_W'(x_reg);
            end
        endcase
    end

    assign res_q = div_done ? div_q : '0;
    assign rate_sat  = (res_q > DVD_W'(RATE_ONE_Q8)) ? RATE_W'(RATE_ONE_Q8)
                     : RATE_W'(res_q);
    assign have = (r_reg < m_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        full_next      = full_reg;
        ka_next        = ka_reg;
        kb_next        = kb_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        inst_next      = inst_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        ins_next       = ins_reg;
        skip_next      = skip_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        med_next       = med_reg;
        worst_next     = worst_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ring_re        = 1'b0;
        ring_we        = 1'b0;
        srt_re         = 1'b0;
        emit           = 1'b0;
        emit_val       = x_reg;
        div_start      = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // fetch the sample about to be overwritten
                    ring_re   = 1'b1;
                    x_next    = s_axis_tdata[SAMPLE_W-1:0];
                    m_next    = cnt_reg;
                    full_next = (cnt_reg == CNT_W'(WINDOW_DEPTH));
                    n_next    = (cnt_reg == CNT_W'(WINDOW_DEPTH)) ? cnt_reg
                                                                  : cnt_reg + 1'b1;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                e_next   = ring_rdata;
                ring_we  = 1'b1;
                wp_next  = (wp_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                cnt_next = n_reg;
                pa_next  = PROD_W'(n_reg) * PROD_W'(fa_reg);
                pb_next  = PROD_W'(n_reg) * PROD_W'(fb_reg);
                state_next = ST_KSCALE;
            end
            ST_KSCALE:
            begin
                // latch both k values and start the merge
                ka_next    = ka_clamped;
                kb_next    = kb_clamped;
                r_next     = '0;
                w_next     = '0;
                ins_next   = 1'b0;
                skip_next  = 1'b0;
                sum_a_next = '0;
                sum_b_next = '0;
                med_next   = '0;
                worst_next = '0;
                state_next = ST_RD;
            end
            ST_DIV_GO:
            begin
                if (dvs == '0)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                res_valid = div_done;
            end
            ST_RD:
            begin
                srt_re     = have;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (w_reg == n_reg)
                begin
                    // list rebuilt: swap buffers, go on with the rates
                    sel_next   = !sel_reg;
                    op_next    = OP_RA;
                    state_next = ST_DIV_GO;
                end
                else if (have && full_reg && !skip_reg && old_d == e_reg)
                begin
                    // drop the evicted sample once
                    skip_next  = 1'b1;
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RD;
                end
                else if (!ins_reg && (!have || old_d > x_reg))
                begin
                    // insert the new sample; hold the read data for the next cycle
                    emit     = 1'b1;
                    emit_val = x_reg;
                    ins_next = 1'b1;
                end
                else if (have)
                begin
                    emit       = 1'b1;
                    emit_val   = old_d;
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    w_next = n_reg;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, COUNT_OUT_W'(n_reg), worst_reg, med_reg,
                                      rb_reg, ra_reg, inst_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            w_next = w_reg + 1'b1;
            if (w_reg >= n_reg - ka_reg)
            begin
                sum_a_next = sum_a_reg + SUM_W'(emit_val);
            end
            if (w_reg >= n_reg - kb_reg)
            begin
                sum_b_next = sum_b_reg + SUM_W'(emit_val);
            end
            if (w_reg == (n_reg >> 1))
            begin
                med_next = emit_val;
            end
            if (w_reg == n_reg - 1'b1)
            begin
                worst_next = emit_val;
            end
        end

        // store a finished quotient and advance to the next one, or to the output after the last
        if (res_valid)
        begin
            case (op_reg)
                OP_RA:
                begin
                    ra_next    = rate_sat;
                    op_next    = OP_RB;
                    state_next = ST_DIV_GO;
                end
                OP_RB:
                begin
                    rb_next    = rate_sat;
                    op_next    = OP_INST;
                    state_next = ST_DIV_GO;
                end
                default:
                begin
                    inst_next  = rate_sat;
                    state_next = ST_FIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_RA;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        e_reg        <= e_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        full_reg     <= full_next;
        ka_reg       <= ka_next;
        kb_reg       <= kb_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        inst_reg     <= inst_next;
        r_reg        <= r_next;
        w_reg        <= w_next;
        ins_reg      <= ins_next;
        skip_reg     <= skip_next;
        sum_a_reg    <= sum_a_next;
        sum_b_reg    <= sum_b_next;
        med_reg      <= med_next;
        worst_reg    <= worst_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (w_reg < n_reg))
        else $error("sorted write beyond window count");

    a_merge_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && w_reg == n_reg) |-> ins_reg)
        else $error("merge ended without insert");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule
